### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define CHK_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CHK_PROP(lbl, clk, rstn, prop)
`define CHK_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### design/mfep_pkg.sv
package mfep_pkg;

  // Parse phases
  localparam logic [3:0] PH_HDR    = 4'd0;
  localparam logic [3:0] PH_TRK    = 4'd1;
  localparam logic [3:0] PH_STOP   = 4'd2;
  localparam logic [3:0] PH_DELTA  = 4'd3;
  localparam logic [3:0] PH_STATUS = 4'd4;
  localparam logic [3:0] PH_DATA1  = 4'd5;
  localparam logic [3:0] PH_DATA2  = 4'd6;
  localparam logic [3:0] PH_MTYPE  = 4'd7;
  localparam logic [3:0] PH_MLEN   = 4'd8;
  localparam logic [3:0] PH_SXLEN  = 4'd9;
  localparam logic [3:0] PH_SKIP   = 4'd10;

  // Result kinds
  localparam logic [3:0] K_NOTE_OFF    = 4'd0;
  localparam logic [3:0] K_TRACK_OK    = 4'd1;
  localparam logic [3:0] K_TRACK_BAD   = 4'd2;
  localparam logic [3:0] K_FORMAT_REJ  = 4'd3;
  localparam logic [3:0] K_UNK_META    = 4'd4;
  localparam logic [3:0] K_OTHER_CHAN  = 4'd5;
  localparam logic [3:0] K_UNSUPPORTED = 4'd6;
  localparam logic [3:0] K_NOTE_IGN    = 4'd7;
  localparam logic [3:0] K_SYSEX_SKIP  = 4'd8;

  // Status and meta bytes
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_TEMPO  = 8'h51;

  // Arithmetic unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam int MUL_STEPS = 15;
  localparam int DIV_STEPS = 24;

  typedef struct packed {
    logic        go;
    logic        op;
    logic [27:0] opa;
    logic [25:0] opb;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [42:0] result;
  } alu_rsp_t;

  // Top octave of the note table in Q16 (notes 120 to 131).
  localparam logic [29:0] OCT_TOP_Q16 [12] = '{
    30'd548668578, 30'd581294109, 30'd615859655, 30'd652480576,
    30'd691279090, 30'd732384684, 30'd775934544, 30'd822074013,
    30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
  };

  function automatic logic meta_known(input logic [7:0] t);
    return (t <= 8'h07) || (t == 8'h20) || (t == 8'h21) || (t == 8'h2F) ||
           (t == 8'h51) || (t == 8'h54) || (t == 8'h58) || (t == 8'h59) ||
           (t == 8'h7F);
  endfunction

  function automatic logic [21:0] note_freq(input logic [6:0] n);
    logic [3:0]  oct;
    logic [6:0]  semi;
    logic [4:0]  s;
    logic [30:0] sum;
    oct = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (n >= 7'(12 * k)) oct = 4'(k);
    end
    semi = n - 7'(oct) * 7'd12;
    s    = 5'd18 - 5'(oct);
    sum  = 31'(OCT_TOP_Q16[semi[3:0]]) + (31'd1 << (s - 5'd1));
    return 22'(sum >> s);
  endfunction

endpackage

### design/mfep_seq_alu.sv
`include "assert_macros.svh"

module mfep_seq_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  mfep_pkg::alu_req_t req,
  output mfep_pkg::alu_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        op_r, op_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [42:0] acc_r, acc_nxt;
  logic [42:0] sh_r, sh_nxt;
  logic [25:0] mp_r, mp_nxt;

  logic        sub;
  logic [42:0] add_a;
  logic [43:0] add_bx;
  logic [43:0] sum;
  logic [42:0] partial;

  // One adder serves both the shift-add multiply and the restoring divide.
  always_comb begin
    partial = {acc_r[41:0], sh_r[23]};
    sub     = (op_r == mfep_pkg::OP_DIV);
    add_a   = sub ? partial : acc_r;
    add_bx  = sub ? ~{18'd0, mp_r} : {1'b0, sh_r};
    sum     = {1'b0, add_a} + add_bx + 44'(sub);
  end

  always_comb begin
    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    mp_nxt   = mp_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      acc_nxt  = '0;
      if (req.op == mfep_pkg::OP_MUL) begin
        cnt_nxt = 5'(mfep_pkg::MUL_STEPS - 1);
        sh_nxt  = {15'd0, req.opa};
      end else begin
        cnt_nxt = 5'(mfep_pkg::DIV_STEPS - 1);
        sh_nxt  = {15'd0, req.opa};
      end
      mp_nxt = req.opb;
    end else if (busy_r) begin
      if (op_r == mfep_pkg::OP_MUL) begin
        if (mp_r[0]) acc_nxt = sum[42:0];
        sh_nxt = {sh_r[41:0], 1'b0};
        mp_nxt = {1'b0, mp_r[25:1]};
      end else begin
        acc_nxt = sum[43] ? partial : sum[42:0];
        sh_nxt  = {sh_r[41:0], ~sum[43]};
      end
      if (cnt_r == 5'd0) busy_nxt = 1'b0;
      else cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      op_r   <= mfep_pkg::OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    mp_r  <= mp_nxt;
  end

  // The result is valid in the cycle after the last step.
  logic done_r;
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else done_r <= busy_r && !req.go && (cnt_r == 5'd0);
  end

  assign rsp.done   = done_r;
  assign rsp.result = (op_r == mfep_pkg::OP_MUL) ? acc_r : {28'd0, sh_r[14:0]};

  `CHK_NEVER(a_go_when_busy, clk, rst_n, req.go && busy_r)
  `CHK_PROP(a_go_starts, clk, rst_n, req.go |=> busy_r)
  `CHK_PROP(a_done_after_busy, clk, rst_n, rsp.done |-> (!busy_r && $past(busy_r)))
  `CHK_PROP(a_cnt_range, clk, rst_n,
            busy_r |-> (cnt_r < 5'(mfep_pkg::DIV_STEPS)))

endmodule

### design/midi_file_event_parser_core.sv
// MIDI file event parser.
// The file is streamed in one byte per input item on in_tdata; in_tuser set
// on an item restarts parsing at the file header with that byte. Results
// leave on the out_ channel, at most one per input item, in input order.
// For most bytes the item is accepted and its result, if any, is in the
// output register in the next cycle. A note-off result waits for the
// 15-step shift-add multiply of delta ticks by ms per tick in the
// shared arithmetic unit. The last byte of a tempo meta event waits for
// the 24-step restoring divide in the same unit.
// in_tready is low while the unit runs, and while a result waits in the
// output register and out_tready is low; a stalled receiver therefore
// holds the input side after one pending result.
// Synchronous reset (rst_n low) returns the parser to the file header and
// drops any pending result.
module midi_file_event_parser_core #(
  parameter int DELTA_MAX_BYTES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // track_number, note_number, velocity, delta_ticks,
                                   // duration_ms, frequency_q8, zero pad
  output logic [3:0]   out_tuser   // kind
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_MUL  = 2'd1;
  localparam logic [1:0] C_DIV  = 2'd2;

  logic [1:0]  ctl_r, ctl_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [15:0] div_r, div_nxt;
  logic [15:0] ntrk_r, ntrk_nxt;
  logic [15:0] tidx_r, tidx_nxt;
  logic [31:0] tlen_r, tlen_nxt;
  logic [31:0] tseen_r, tseen_nxt;
  logic [27:0] delta_r, delta_nxt;
  logic [7:0]  stat_r, stat_nxt;
  logic [7:0]  mkind_r, mkind_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [23:0] tempo_r, tempo_nxt;
  logic [14:0] mspt_r, mspt_nxt;
  logic [7:0]  note_r, note_nxt;

  logic        oval_r, oval_nxt;
  logic [3:0]  okind_r;
  logic [15:0] otrk_r;
  logic [6:0]  onote_r;
  logic [6:0]  ovel_r;
  logic [27:0] odelta_r;
  logic [42:0] odur_r;
  logic [21:0] ofreq_r;

  logic        acc;
  logic        emit;
  logic [3:0]  ekind;
  logic [27:0] edelta;
  logic [6:0]  evel;
  logic        mul_go;
  logic        div_go;
  logic        fin;
  logic [25:0] divisor;

  mfep_pkg::alu_req_t alu_req;
  mfep_pkg::alu_rsp_t alu_rsp;

  assign in_tready = (ctl_r == C_IDLE) && (!oval_r || out_tready);
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    logic [7:0] b;
    logic       is_chan_c;
    b = in_tdata;
    phase_nxt = phase_r;  fcnt_nxt = fcnt_r;   div_nxt = div_r;
    ntrk_nxt  = ntrk_r;   tidx_nxt = tidx_r;   tlen_nxt = tlen_r;
    tseen_nxt = tseen_r;  delta_nxt = delta_r; stat_nxt = stat_r;
    mkind_nxt = mkind_r;  skip_nxt = skip_r;   tempo_nxt = tempo_r;
    mspt_nxt  = mspt_r;   note_nxt = note_r;
    emit = 1'b0; ekind = mfep_pkg::K_NOTE_OFF; edelta = 28'd0; evel = 7'd0;
    mul_go = 1'b0; div_go = 1'b0; fin = 1'b0;
    if (in_tuser) begin
      phase_nxt = mfep_pkg::PH_HDR; fcnt_nxt = '0; div_nxt = '0; ntrk_nxt = '0;
      tidx_nxt = '0; tlen_nxt = '0; tseen_nxt = '0; delta_nxt = '0;
      stat_nxt = '0; mkind_nxt = '0; skip_nxt = '0; tempo_nxt = '0;
      mspt_nxt = '0; note_nxt = '0;
    end
    if (phase_nxt >= mfep_pkg::PH_DELTA && phase_nxt <= mfep_pkg::PH_SKIP &&
        tseen_nxt != 32'hFFFF_FFFF)
      tseen_nxt = tseen_nxt + 32'd1;
    is_chan_c = (stat_nxt >= 8'hC0) && (stat_nxt <= 8'hDF);

    unique case (phase_nxt)
      mfep_pkg::PH_HDR: begin
        if (fcnt_nxt == 4'd9 && {div_nxt[7:0], b} == 16'd2) begin
          phase_nxt = mfep_pkg::PH_STOP;
          emit = 1'b1; ekind = mfep_pkg::K_FORMAT_REJ;
        end else begin
          if (fcnt_nxt == 4'd8) div_nxt = {8'd0, b};
          else if (fcnt_nxt == 4'd10 || fcnt_nxt == 4'd11) ntrk_nxt = {ntrk_nxt[7:0], b};
          else if (fcnt_nxt >= 4'd12) div_nxt = {div_nxt[7:0], b};
          if (fcnt_nxt >= 4'd13) begin
            tidx_nxt = '0;
            fcnt_nxt = '0;
            phase_nxt = (ntrk_nxt != 16'd0) ? mfep_pkg::PH_TRK : mfep_pkg::PH_STOP;
          end else begin
            fcnt_nxt = fcnt_nxt + 4'd1;
          end
        end
      end
      mfep_pkg::PH_TRK: begin
        if (fcnt_nxt == 4'd0) tidx_nxt = tidx_nxt + 16'd1;
        if (fcnt_nxt >= 4'd4) tlen_nxt = {tlen_nxt[23:0], b};
        if (fcnt_nxt >= 4'd7) begin
          tseen_nxt = '0; stat_nxt = '0;
          phase_nxt = mfep_pkg::PH_DELTA; fcnt_nxt = '0; delta_nxt = '0;
        end else begin
          fcnt_nxt = fcnt_nxt + 4'd1;
        end
      end
      mfep_pkg::PH_DELTA: begin
        delta_nxt = {delta_nxt[20:0], b[6:0]};
        fcnt_nxt  = fcnt_nxt + 4'd1;
        if (!b[7] || fcnt_nxt >= 4'(DELTA_MAX_BYTES)) phase_nxt = mfep_pkg::PH_STATUS;
      end
      mfep_pkg::PH_STATUS, mfep_pkg::PH_DATA1: begin
        if (phase_nxt == mfep_pkg::PH_STATUS && b == mfep_pkg::ST_META) begin
          stat_nxt = b; phase_nxt = mfep_pkg::PH_MTYPE;
        end else if (phase_nxt == mfep_pkg::PH_STATUS &&
                     (b == mfep_pkg::ST_SYSEX || b == mfep_pkg::ST_SYSEX_ESC)) begin
          stat_nxt = b; phase_nxt = mfep_pkg::PH_SXLEN;
        end else if (phase_nxt == mfep_pkg::PH_STATUS && b >= 8'h80 && b <= 8'hEF) begin
          stat_nxt = b; phase_nxt = mfep_pkg::PH_DATA1;
        end else if (phase_nxt == mfep_pkg::PH_DATA1 ||
                     (!b[7] && stat_nxt >= 8'h80 && stat_nxt <= 8'hEF)) begin
          note_nxt = b;
          if (is_chan_c) begin
            emit = 1'b1; ekind = mfep_pkg::K_OTHER_CHAN; edelta = delta_nxt;
            phase_nxt = mfep_pkg::PH_DELTA; fcnt_nxt = '0; delta_nxt = '0;
          end else begin
            phase_nxt = mfep_pkg::PH_DATA2;
          end
        end else begin
          emit = 1'b1; ekind = mfep_pkg::K_UNSUPPORTED; edelta = delta_nxt;
          stat_nxt = '0;
          phase_nxt = mfep_pkg::PH_DELTA; fcnt_nxt = '0; delta_nxt = '0;
        end
      end
      mfep_pkg::PH_DATA2: begin
        emit = 1'b1; edelta = delta_nxt;
        if (stat_nxt[7:4] == 4'h8) begin
          if (note_nxt[7]) begin
            ekind = mfep_pkg::K_NOTE_IGN;
          end else begin
            ekind = mfep_pkg::K_NOTE_OFF; evel = b[6:0]; mul_go = 1'b1;
          end
        end else begin
          ekind = mfep_pkg::K_OTHER_CHAN;
        end
        phase_nxt = mfep_pkg::PH_DELTA; fcnt_nxt = '0; delta_nxt = '0;
      end
      mfep_pkg::PH_MTYPE: begin
        mkind_nxt = b;
        if (!mfep_pkg::meta_known(b)) begin
          emit = 1'b1; ekind = mfep_pkg::K_UNK_META; edelta = delta_nxt;
        end
        phase_nxt = mfep_pkg::PH_MLEN;
      end
      mfep_pkg::PH_MLEN: begin
        skip_nxt = b;
        if (mkind_nxt == mfep_pkg::META_TEMPO) tempo_nxt = '0;
        if (b == 8'd0) fin = 1'b1;
        else phase_nxt = mfep_pkg::PH_SKIP;
      end
      mfep_pkg::PH_SXLEN: begin
        emit = 1'b1; ekind = mfep_pkg::K_SYSEX_SKIP; edelta = delta_nxt;
        skip_nxt = b;
        if (b == 8'd0) fin = 1'b1;
        else phase_nxt = mfep_pkg::PH_SKIP;
      end
      mfep_pkg::PH_SKIP: begin
        if (stat_nxt == mfep_pkg::ST_META && mkind_nxt == mfep_pkg::META_TEMPO)
          tempo_nxt = {tempo_nxt[15:0], b};
        skip_nxt = skip_nxt - 8'd1;
        if (skip_nxt == 8'd0) fin = 1'b1;
      end
      default: begin
      end
    endcase

    // End of a meta or sysex body.
    if (fin) begin
      if (stat_nxt == mfep_pkg::ST_META && mkind_nxt == mfep_pkg::META_TEMPO) begin
        if (div_nxt == 16'd0) mspt_nxt = '0;
        else div_go = 1'b1;
      end
      if (stat_nxt == mfep_pkg::ST_META && mkind_nxt == mfep_pkg::META_EOT) begin
        emit = 1'b1; edelta = delta_nxt;
        ekind = (tseen_nxt == tlen_nxt) ? mfep_pkg::K_TRACK_OK : mfep_pkg::K_TRACK_BAD;
        fcnt_nxt = '0;
        phase_nxt = (tidx_nxt < ntrk_nxt) ? mfep_pkg::PH_TRK : mfep_pkg::PH_STOP;
      end else begin
        phase_nxt = mfep_pkg::PH_DELTA; fcnt_nxt = '0; delta_nxt = '0;
      end
    end

    if (stat_nxt != mfep_pkg::ST_META && phase_nxt == mfep_pkg::PH_DELTA &&
        (stat_nxt == mfep_pkg::ST_SYSEX || stat_nxt == mfep_pkg::ST_SYSEX_ESC))
      stat_nxt = '0;
    if (stat_nxt == mfep_pkg::ST_META && phase_nxt != mfep_pkg::PH_MTYPE &&
        phase_nxt != mfep_pkg::PH_MLEN && phase_nxt != mfep_pkg::PH_SKIP)
      stat_nxt = '0;
  end

  // 1000 = 1024 - 16 - 8
  assign divisor = ({10'd0, div_nxt} << 10) - ({10'd0, div_nxt} << 4) -
                   ({10'd0, div_nxt} << 3);

  always_comb begin
    alu_req.go  = acc && (mul_go || div_go);
    alu_req.op  = div_go ? mfep_pkg::OP_DIV : mfep_pkg::OP_MUL;
    alu_req.opa = div_go ? {4'd0, tempo_nxt} : delta_r;
    alu_req.opb = div_go ? divisor : {11'd0, mspt_r};
  end

  mfep_seq_alu u_alu (
    .clk (clk),
    .rst_n (rst_n),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  always_comb begin
    ctl_nxt  = ctl_r;
    oval_nxt = oval_r;
    if (oval_r && out_tready) oval_nxt = 1'b0;
    unique case (ctl_r)
      C_IDLE: begin
        if (acc) begin
          if (mul_go) ctl_nxt = C_MUL;
          else if (div_go) ctl_nxt = C_DIV;
          if (emit && !mul_go) oval_nxt = 1'b1;
        end
      end
      C_MUL: begin
        if (alu_rsp.done) begin
          ctl_nxt  = C_IDLE;
          oval_nxt = 1'b1;
        end
      end
      C_DIV: begin
        if (alu_rsp.done) ctl_nxt = C_IDLE;
      end
      default: ctl_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= C_IDLE;
      oval_r  <= 1'b0;
      phase_r <= mfep_pkg::PH_HDR;
      fcnt_r  <= '0;  div_r  <= '0;  ntrk_r  <= '0;  tidx_r  <= '0;
      tlen_r  <= '0;  tseen_r <= '0; delta_r <= '0;  stat_r  <= '0;
      mkind_r <= '0;  skip_r <= '0;  tempo_r <= '0;  mspt_r  <= '0;
      note_r  <= '0;
    end else begin
      ctl_r  <= ctl_nxt;
      oval_r <= oval_nxt;
      if (acc) begin
        phase_r <= phase_nxt; fcnt_r <= fcnt_nxt; div_r <= div_nxt;
        ntrk_r <= ntrk_nxt; tidx_r <= tidx_nxt; tlen_r <= tlen_nxt;
        tseen_r <= tseen_nxt; delta_r <= delta_nxt; stat_r <= stat_nxt;
        mkind_r <= mkind_nxt; skip_r <= skip_nxt; tempo_r <= tempo_nxt;
        mspt_r <= mspt_nxt; note_r <= note_nxt;
      end else if (ctl_r == C_DIV && alu_rsp.done) begin
        mspt_r <= alu_rsp.result[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && emit) begin
      okind_r  <= ekind;
      otrk_r   <= tidx_nxt;
      odelta_r <= edelta;
      ovel_r   <= evel;
      onote_r  <= mul_go ? note_r[6:0] : 7'd0;
      ofreq_r  <= mul_go ? mfep_pkg::note_freq(note_r[6:0]) : 22'd0;
      odur_r   <= '0;
    end else if (ctl_r == C_MUL && alu_rsp.done) begin
      odur_r <= alu_rsp.result;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {5'b0, ofreq_r, odur_r, odelta_r, ovel_r, onote_r, otrk_r};
  assign out_tuser  = okind_r;

  `CHK_NEVER(a_accept_when_busy, clk, rst_n, acc && (ctl_r != C_IDLE))
  `CHK_PROP(a_mul_fills_output, clk, rst_n,
            (ctl_r == C_MUL && alu_rsp.done) |=> oval_r)
  `CHK_NEVER(a_no_result_during_mul, clk, rst_n, (ctl_r == C_MUL) && oval_r)

endmodule
